// ===== src/wern_pkg.sv =====
// shared types, codes and helpers for the weighted error ratio norm unit
package wern_pkg;

  localparam int unsigned MAX_LENGTH_DEF = 65536;
  localparam logic [31:0] ABS_TOL_RESET = 32'd65536;

  localparam logic [1:0] CFG_REL_TOL = 2'd0;
  localparam logic [1:0] CFG_ABS_TOL = 2'd1;
  localparam logic [1:0] CFG_NORM_MODE = 2'd2;
  localparam logic [1:0] CFG_COMPLEX = 2'd3;

  localparam logic [2:0] NORM_MAX = 3'd0;
  localparam logic [2:0] NORM_SUM = 3'd1;
  localparam logic [2:0] NORM_MEAN = 3'd2;
  localparam logic [2:0] NORM_L2 = 3'd3;
  localparam logic [2:0] NORM_RMS = 3'd4;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_BAD_MODE = 2'd2;

  typedef struct packed {
    logic start;
    logic sqrt;
  } iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_rsp_t;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    abs32 = v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ===== src/wern_iter.sv =====
// shared bit-serial divider and square root unit
module wern_iter
  import wern_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  iter_req_t   req,
  input  logic [63:0] a,
  input  logic [63:0] d,
  output iter_rsp_t   rsp,
  output logic [63:0] result
);

  logic        busy;
  logic        done;
  logic        is_sqrt;
  logic [5:0]  step;
  logic [63:0] shreg;
  logic [64:0] rem;
  logic [31:0] root;
  logic [63:0] d_q;

  logic [65:0] cand;
  logic [65:0] sub;
  logic [65:0] diff;
  logic        ge;

  always_comb begin
    if (is_sqrt) begin
      cand = {rem[63:0], shreg[63:62]};
      sub = {32'd0, root, 2'b01};
    end else begin
      cand = {rem, shreg[63]};
      sub = {2'b00, d_q};
    end
    ge = (cand >= sub);
    diff = cand - sub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        is_sqrt <= req.sqrt;
        step <= req.sqrt ? 6'd31 : 6'd63;
        shreg <= a;
        rem <= '0;
        root <= '0;
        d_q <= d;
      end else if (busy) begin
        rem <= ge ? diff[64:0] : cand[64:0];
        if (is_sqrt) begin
          root <= {root[30:0], ge};
          shreg <= {shreg[61:0], 2'b00};
        end else begin
          shreg <= {shreg[62:0], ge};
        end
        if (step == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 6'd1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign result = is_sqrt ? {32'd0, root} : shreg;

endmodule

// ===== src/weighted_error_ratio_norm_unit.sv =====
// top level of the weighted error ratio norm unit
// Usage: elements arrive on the in_valid/in_ready channel, each with x and dx
// (real, or real and imaginary when complex mode is set) and a last flag.
// Each element yields r = |dx| / (abs_tol + rel_tol*|x|), folded into an
// accumulator by the selected norm. The element marked last produces one
// result (norm_value, status) on the out_valid/out_ready channel; the
// accumulator, count and invalid flag then clear.
// Timing: in_ready is high only while idle. Divides and roots run on the
// shared bit-serial divide/square-root unit (64 steps per divide, 32 per root).
// For a last element, mean and RMS modes add a divide and L2 and RMS modes a
// square root before the output handshake. A shared 32x32 multiplier forms
// squares and products.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at once and must
// be made while idle. A synchronous rst returns to idle and clears out_valid,
// accumulator, count and invalid flag and restores the register defaults.
// While the receiver stalls the result holds and no new element is taken.
module weighted_error_ratio_norm_unit
  import wern_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] x_real,
  input  logic [31:0] x_imag,
  input  logic [31:0] dx_real,
  input  logic [31:0] dx_imag,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] norm_value,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_LENGTH + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQ_A = 4'd1;
  localparam logic [3:0] ST_SQ_B = 4'd2;
  localparam logic [3:0] ST_SQ_C = 4'd3;
  localparam logic [3:0] ST_SQ_W = 4'd4;
  localparam logic [3:0] ST_DEN_M = 4'd5;
  localparam logic [3:0] ST_DEN_A = 4'd6;
  localparam logic [3:0] ST_DEN_C = 4'd7;
  localparam logic [3:0] ST_DIV_W = 4'd8;
  localparam logic [3:0] ST_FOLD_M = 4'd9;
  localparam logic [3:0] ST_FOLD_A = 4'd10;
  localparam logic [3:0] ST_FIN = 4'd11;
  localparam logic [3:0] ST_RES_DIV = 4'd12;
  localparam logic [3:0] ST_RES_SQ = 4'd13;
  localparam logic [3:0] ST_OUT = 4'd14;

  logic [31:0] rel_tol;
  logic [31:0] abs_tol;
  logic [2:0]  norm_mode;
  logic        complex_mode;

  logic [3:0]  state;
  logic        phase;
  logic [31:0] xr, xi, dxr, dxi;
  logic        last_q;
  logic [31:0] mx, mdx;
  logic [63:0] sqa;
  logic [63:0] prod;
  logic [48:0] den;
  logic [47:0] r;
  logic [63:0] accumulator;
  logic [CNT_W-1:0] element_count;
  logic        invalid_seen;

  logic [31:0] mul_a, mul_b;
  logic [31:0] mag_a, mag_b;
  iter_req_t   it_req;
  iter_rsp_t   it_rsp;
  logic [63:0] it_a, it_d, it_res;
  logic [63:0] term;
  logic [64:0] acc_sum;

  assign mag_a = abs32(phase ? dxr : xr);
  assign mag_b = abs32(phase ? dxi : xi);

  always_comb begin
    unique case (state)
      ST_SQ_A: begin
        mul_a = mag_a;
        mul_b = mag_a;
      end
      ST_SQ_B: begin
        mul_a = mag_b;
        mul_b = mag_b;
      end
      ST_DEN_M: begin
        mul_a = rel_tol;
        mul_b = mx;
      end
      default: begin
        mul_a = r[31:0];
        mul_b = r[31:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // operands to the shared divide / root unit
  always_comb begin
    it_req = '0;
    it_a = '0;
    it_d = '0;
    unique case (state)
      ST_SQ_C: begin
        it_req.start = 1'b1;
        it_req.sqrt = 1'b1;
        it_a = sqa + prod;
      end
      ST_DEN_C: begin
        it_req.start = (den != '0);
        it_a = {16'd0, mdx, 16'd0};
        it_d = {15'd0, den};
      end
      ST_FIN: begin
        if (last_q && !invalid_seen) begin
          if (norm_mode == NORM_MEAN || norm_mode == NORM_RMS) begin
            it_req.start = 1'b1;
            it_a = accumulator;
            it_d = 64'(element_count);
          end else if (norm_mode == NORM_L2) begin
            it_req.start = 1'b1;
            it_req.sqrt = 1'b1;
            it_a = accumulator;
          end
        end
      end
      ST_RES_DIV: begin
        if (it_rsp.done && norm_mode == NORM_RMS) begin
          it_req.start = 1'b1;
          it_req.sqrt = 1'b1;
          it_a = it_res;
        end
      end
      default: begin
      end
    endcase
  end

  wern_iter u_iter (
    .clk    (clk),
    .rst    (rst),
    .req    (it_req),
    .a      (it_a),
    .d      (it_d),
    .rsp    (it_rsp),
    .result (it_res)
  );

  always_comb begin
    if (norm_mode == NORM_L2 || norm_mode == NORM_RMS) begin
      term = (r[47:32] != '0) ? '1 : prod;
    end else begin
      term = {r, 16'd0};
    end
    acc_sum = {1'b0, accumulator} + {1'b0, term};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rel_tol <= '0;
      abs_tol <= ABS_TOL_RESET;
      norm_mode <= NORM_MAX;
      complex_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REL_TOL: rel_tol <= cfg_data;
        CFG_ABS_TOL: abs_tol <= cfg_data;
        CFG_NORM_MODE: norm_mode <= cfg_data[2:0];
        CFG_COMPLEX: complex_mode <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      accumulator <= '0;
      element_count <= '0;
      invalid_seen <= 1'b0;
      phase <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            xr <= x_real;
            xi <= x_imag;
            dxr <= dx_real;
            dxi <= dx_imag;
            last_q <= last;
            phase <= 1'b0;
            if (complex_mode) begin
              state <= ST_SQ_A;
            end else begin
              mx <= abs32(x_real);
              mdx <= abs32(dx_real);
              state <= ST_DEN_M;
            end
          end
        end
        ST_SQ_A: state <= ST_SQ_B;
        ST_SQ_B: begin
          sqa <= prod;
          state <= ST_SQ_C;
        end
        ST_SQ_C: state <= ST_SQ_W;
        ST_SQ_W: begin
          if (it_rsp.done) begin
            if (phase) begin
              mdx <= it_res[31:0];
              state <= ST_DEN_M;
            end else begin
              mx <= it_res[31:0];
              phase <= 1'b1;
              state <= ST_SQ_A;
            end
          end
        end
        ST_DEN_M: state <= ST_DEN_A;
        ST_DEN_A: begin
          den <= {17'd0, abs_tol} + {1'b0, prod[63:16]};
          state <= ST_DEN_C;
        end
        ST_DEN_C: begin
          if (element_count < CNT_W'(MAX_LENGTH)) begin
            element_count <= element_count + CNT_W'(1);
          end
          if (den == '0) begin
            invalid_seen <= 1'b1;
            state <= ST_FIN;
          end else begin
            state <= ST_DIV_W;
          end
        end
        ST_DIV_W: begin
          if (it_rsp.done) begin
            r <= it_res[47:0];
            state <= ST_FOLD_M;
          end
        end
        ST_FOLD_M: state <= ST_FOLD_A;
        ST_FOLD_A: begin
          if (norm_mode == NORM_MAX) begin
            if (term > accumulator) accumulator <= term;
          end else if (norm_mode <= NORM_RMS) begin
            accumulator <= acc_sum[64] ? '1 : acc_sum[63:0];
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!last_q) begin
            state <= ST_IDLE;
          end else begin
            accumulator <= '0;
            element_count <= '0;
            invalid_seen <= 1'b0;
            if (invalid_seen) begin
              norm_value <= '0;
              status <= STAT_INVALID;
              out_valid <= 1'b1;
              state <= ST_OUT;
            end else if (norm_mode == NORM_MAX || norm_mode == NORM_SUM) begin
              norm_value <= accumulator[63:16];
              status <= STAT_OK;
              out_valid <= 1'b1;
              state <= ST_OUT;
            end else if (norm_mode == NORM_MEAN || norm_mode == NORM_RMS) begin
              status <= STAT_OK;
              state <= ST_RES_DIV;
            end else if (norm_mode == NORM_L2) begin
              status <= STAT_OK;
              state <= ST_RES_SQ;
            end else begin
              norm_value <= '0;
              status <= STAT_BAD_MODE;
              out_valid <= 1'b1;
              state <= ST_OUT;
            end
          end
        end
        ST_RES_DIV: begin
          if (it_rsp.done) begin
            if (norm_mode == NORM_RMS) begin
              state <= ST_RES_SQ;
            end else begin
              norm_value <= it_res[63:16];
              out_valid <= 1'b1;
              state <= ST_OUT;
            end
          end
        end
        ST_RES_SQ: begin
          if (it_rsp.done) begin
            norm_value <= {16'd0, it_res[31:0]};
            out_valid <= 1'b1;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("result pending while idle");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != 2'd3)) else $error("bad status code");

  a_iter_idle: assert property (@(posedge clk) disable iff (rst)
    (it_rsp.busy || it_rsp.done) |-> (state != ST_IDLE && state != ST_OUT))
    else $error("iterative unit active with no consumer");

endmodule
